// ===== design/aatcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the box-against-tile collision resolver.
package aatcr_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int TILE_BITS      = 8;
    localparam int SIZE_BITS      = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [TILE_BITS-1:0] TILE_SIZE_RST = 8'd16;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TILE = 1'b1;

    typedef struct packed {
        logic kind;
        logic solid;
    } t_ctrl;

endpackage

// ===== design/aatcr_front.sv =====
`timescale 1ns / 1ps
// Front end: tile size register, word classification and tile edge precompute.
module aatcr_front #(
    parameter int COORD_BITS = aatcr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = aatcr_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aatcr_pkg::TILE_BITS-1:0]     i_cfg_data,
    input  logic                                i_kind,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic [aatcr_pkg::SIZE_BITS-1:0]     i_size_w,
    input  logic [aatcr_pkg::SIZE_BITS-1:0]     i_size_h,
    input  logic signed [COORD_BITS-1:0]        i_speed_x,
    input  logic signed [COORD_BITS-1:0]        i_speed_y,
    input  logic signed [COORD_BITS-1:0]        i_tile_x,
    input  logic signed [COORD_BITS-1:0]        i_tile_y,
    input  logic                                i_solid,
    output aatcr_pkg::t_ctrl                    o_ctrl,
    output logic [4*COORD_BITS+2*aatcr_pkg::SIZE_BITS
                  +5*(((COORD_BITS > aatcr_pkg::TILE_BITS+FRAC_BITS) ? COORD_BITS
                       : aatcr_pkg::TILE_BITS+FRAC_BITS)+4)-1:0] o_data
);

    localparam int TB = aatcr_pkg::TILE_BITS + FRAC_BITS;
    localparam int WW = ((COORD_BITS > TB) ? COORD_BITS : TB) + 4;

    logic [aatcr_pkg::TILE_BITS-1:0] r_tile_size;
    logic [TB-1:0]                   w_tile;
    logic signed [WW-1:0]            w_t_ext;
    logic signed [WW-1:0]            w_tx;
    logic signed [WW-1:0]            w_ty;
    logic signed [WW-1:0]            w_ex;
    logic signed [WW-1:0]            w_ey;
    logic signed [WW-1:0]            w_cx2;
    logic signed [WW-1:0]            w_cy2;
    logic signed [COORD_BITS-1:0]    w_a;
    logic signed [COORD_BITS-1:0]    w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size <= aatcr_pkg::TILE_SIZE_RST;
        end else if (i_cfg_we) begin
            r_tile_size <= i_cfg_data;
        end
    end

    assign w_tile  = TB'(r_tile_size) << FRAC_BITS;
    assign w_t_ext = signed'(WW'(w_tile));
    assign w_tx    = {{(WW-COORD_BITS){i_tile_x[COORD_BITS-1]}}, i_tile_x};
    assign w_ty    = {{(WW-COORD_BITS){i_tile_y[COORD_BITS-1]}}, i_tile_y};

    // Right and bottom tile edges, and tile centers at twice the scale
    assign w_ex  = w_tx + w_t_ext;
    assign w_ey  = w_ty + w_t_ext;
    assign w_cx2 = (w_tx <<< 1) + w_t_ext;
    assign w_cy2 = (w_ty <<< 1) + w_t_ext;

    assign w_a = (i_kind == aatcr_pkg::KIND_TILE) ? i_tile_x : i_pos_x;
    assign w_b = (i_kind == aatcr_pkg::KIND_TILE) ? i_tile_y : i_pos_y;

    assign o_ctrl.kind  = i_kind;
    assign o_ctrl.solid = i_solid & (i_kind == aatcr_pkg::KIND_TILE);

    assign o_data = {w_a, w_b, i_size_w, i_size_h, i_speed_x, i_speed_y,
                     w_t_ext, w_ex, w_ey, w_cx2, w_cy2};

endmodule

// ===== design/aatcr_queue.sv =====
`timescale 1ns / 1ps
// Short word queue that decouples the front end from the resolve stage.
module aatcr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = aatcr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push    = i_push && !o_full;
    assign w_pop     = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/aatcr_back.sv =====
`timescale 1ns / 1ps
// Resolve stage: body registers, overlap test, shallow-axis push and result word.
module aatcr_back #(
    parameter int COORD_BITS = aatcr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = aatcr_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_avail,
    input  aatcr_pkg::t_ctrl                 i_ctrl,
    input  logic [4*COORD_BITS+2*aatcr_pkg::SIZE_BITS
                  +5*(((COORD_BITS > aatcr_pkg::TILE_BITS+FRAC_BITS) ? COORD_BITS
                       : aatcr_pkg::TILE_BITS+FRAC_BITS)+4)-1:0] i_data,
    output logic                             o_take,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic signed [COORD_BITS-1:0]     o_new_x,
    output logic signed [COORD_BITS-1:0]     o_new_y,
    output logic signed [COORD_BITS-1:0]     o_new_vx,
    output logic signed [COORD_BITS-1:0]     o_new_vy,
    output logic                             o_hit,
    output logic                             o_pushed_on_y
);

    localparam int TB = aatcr_pkg::TILE_BITS + FRAC_BITS;
    localparam int WW = ((COORD_BITS > TB) ? COORD_BITS : TB) + 4;
    localparam int SB = aatcr_pkg::SIZE_BITS;
    localparam logic signed [WW-1:0] CMAX = {{(WW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [WW-1:0] CMIN = {{(WW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] d_a;
    logic signed [COORD_BITS-1:0] d_b;
    logic [SB-1:0]                d_w;
    logic [SB-1:0]                d_h;
    logic signed [COORD_BITS-1:0] d_vx;
    logic signed [COORD_BITS-1:0] d_vy;
    logic signed [WW-1:0]         d_t;
    logic signed [WW-1:0]         d_ex;
    logic signed [WW-1:0]         d_ey;
    logic signed [WW-1:0]         d_cx2;
    logic signed [WW-1:0]         d_cy2;

    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic [SB-1:0]                r_cur_w;
    logic [SB-1:0]                r_cur_h;
    logic signed [COORD_BITS-1:0] r_cur_vx;
    logic signed [COORD_BITS-1:0] r_cur_vy;
    logic                         r_valid;
    logic                         r_hit;
    logic                         r_on_y;

    logic signed [COORD_BITS-1:0] n_cur_x;
    logic signed [COORD_BITS-1:0] n_cur_y;
    logic [SB-1:0]                n_cur_w;
    logic [SB-1:0]                n_cur_h;
    logic signed [COORD_BITS-1:0] n_cur_vx;
    logic signed [COORD_BITS-1:0] n_cur_vy;
    logic                         n_hit;
    logic                         n_on_y;

    logic                         w_go;
    logic signed [WW-1:0]         w_xs;
    logic signed [WW-1:0]         w_ys;
    logic signed [WW-1:0]         w_ws;
    logic signed [WW-1:0]         w_hs;
    logic signed [WW-1:0]         w_txs;
    logic signed [WW-1:0]         w_tys;
    logic                         w_over;
    logic signed [WW-1:0]         w_dx2;
    logic signed [WW-1:0]         w_dy2;
    logic signed [WW-1:0]         w_adx;
    logic signed [WW-1:0]         w_ady;
    logic signed [WW-1:0]         w_px;
    logic signed [WW-1:0]         w_py;
    logic                         w_push_y;
    logic signed [WW-1:0]         w_mx;
    logic signed [WW-1:0]         w_my;
    logic signed [COORD_BITS-1:0] w_sx;
    logic signed [COORD_BITS-1:0] w_sy;

    assign {d_a, d_b, d_w, d_h, d_vx, d_vy, d_t, d_ex, d_ey, d_cx2, d_cy2} = i_data;

    // Advance when a word is available and the output register is empty or being taken
    assign w_go   = i_avail && (!r_valid || !i_stall);
    assign o_take = w_go;

    assign w_xs  = {{(WW-COORD_BITS){r_cur_x[COORD_BITS-1]}}, r_cur_x};
    assign w_ys  = {{(WW-COORD_BITS){r_cur_y[COORD_BITS-1]}}, r_cur_y};
    assign w_ws  = signed'(WW'(r_cur_w));
    assign w_hs  = signed'(WW'(r_cur_h));
    assign w_txs = {{(WW-COORD_BITS){d_a[COORD_BITS-1]}}, d_a};
    assign w_tys = {{(WW-COORD_BITS){d_b[COORD_BITS-1]}}, d_b};

    assign w_over = (w_xs < d_ex) && (w_xs + w_ws > w_txs) &&
                    (w_ys < d_ey) && (w_ys + w_hs > w_tys);

    // Center offsets at twice the scale, halved into depths; the halved sum is even when overlapping
    assign w_dx2 = ((w_xs <<< 1) + w_ws) - d_cx2;
    assign w_dy2 = ((w_ys <<< 1) + w_hs) - d_cy2;
    assign w_adx = w_dx2[WW-1] ? -w_dx2 : w_dx2;
    assign w_ady = w_dy2[WW-1] ? -w_dy2 : w_dy2;
    assign w_px  = (w_ws + d_t - w_adx) >>> 1;
    assign w_py  = (w_hs + d_t - w_ady) >>> 1;

    // Tie goes to y
    assign w_push_y = !(w_px < w_py);

    assign w_mx = (w_xs < w_txs) ? w_xs - w_px : w_xs + w_px;
    assign w_my = (w_ys < w_tys) ? w_ys - w_py : w_ys + w_py;

    assign w_sx = (w_mx > CMAX) ? CMAX[COORD_BITS-1:0] :
                  (w_mx < CMIN) ? CMIN[COORD_BITS-1:0] : w_mx[COORD_BITS-1:0];
    assign w_sy = (w_my > CMAX) ? CMAX[COORD_BITS-1:0] :
                  (w_my < CMIN) ? CMIN[COORD_BITS-1:0] : w_my[COORD_BITS-1:0];

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_cur_w  = r_cur_w;
        n_cur_h  = r_cur_h;
        n_cur_vx = r_cur_vx;
        n_cur_vy = r_cur_vy;
        n_hit    = 1'b0;
        n_on_y   = 1'b0;
        if (i_ctrl.kind == aatcr_pkg::KIND_LOAD) begin
            n_cur_x  = d_a;
            n_cur_y  = d_b;
            n_cur_w  = d_w;
            n_cur_h  = d_h;
            n_cur_vx = d_vx;
            n_cur_vy = d_vy;
        end else if (i_ctrl.solid && w_over) begin
            n_hit = 1'b1;
            if (w_push_y) begin
                n_on_y   = 1'b1;
                n_cur_y  = w_sy;
                n_cur_vy = '0;
            end else begin
                n_cur_x  = w_sx;
                n_cur_vx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_cur_w  <= '0;
            r_cur_h  <= '0;
            r_cur_vx <= '0;
            r_cur_vy <= '0;
        end else begin
            if (w_go) begin
                r_valid  <= 1'b1;
                r_cur_x  <= n_cur_x;
                r_cur_y  <= n_cur_y;
                r_cur_w  <= n_cur_w;
                r_cur_h  <= n_cur_h;
                r_cur_vx <= n_cur_vx;
                r_cur_vy <= n_cur_vy;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_hit  <= n_hit;
            r_on_y <= n_on_y;
        end
    end

    // Body registers only change when a new word is taken, so they are the result
    assign o_valid       = r_valid;
    assign o_new_x       = r_cur_x;
    assign o_new_y       = r_cur_y;
    assign o_new_vx      = r_cur_vx;
    assign o_new_vy      = r_cur_vy;
    assign o_hit         = r_hit;
    assign o_pushed_on_y = r_on_y;

endmodule

// ===== design/aabb_tile_collision_resolver_top.sv =====
`timescale 1ns / 1ps
// An accepted input word is held in the queue, then resolved into the output registers.
// Throughput: one word per cycle while the output is not stalled, set by the resolve
// stage that reads and updates the body registers for each tile test.
// A two-word queue sits between the front end and the resolve stage.
// Reset (synchronous, active low) empties the queue and output, zeroes the body
// and sets the tile size to 16.
module aabb_tile_collision_resolver_top #(
    parameter int COORD_BITS = aatcr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = aatcr_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [aatcr_pkg::TILE_BITS-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_kind,
    input  logic signed [COORD_BITS-1:0]     i_pos_x,
    input  logic signed [COORD_BITS-1:0]     i_pos_y,
    input  logic [aatcr_pkg::SIZE_BITS-1:0]  i_size_w,
    input  logic [aatcr_pkg::SIZE_BITS-1:0]  i_size_h,
    input  logic signed [COORD_BITS-1:0]     i_speed_x,
    input  logic signed [COORD_BITS-1:0]     i_speed_y,
    input  logic signed [COORD_BITS-1:0]     i_tile_x,
    input  logic signed [COORD_BITS-1:0]     i_tile_y,
    input  logic                             i_solid,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [COORD_BITS-1:0]     o_new_x,
    output logic signed [COORD_BITS-1:0]     o_new_y,
    output logic signed [COORD_BITS-1:0]     o_new_vx,
    output logic signed [COORD_BITS-1:0]     o_new_vy,
    output logic                             o_hit,
    output logic                             o_pushed_on_y
);

    localparam int TB = aatcr_pkg::TILE_BITS + FRAC_BITS;
    localparam int WW = ((COORD_BITS > TB) ? COORD_BITS : TB) + 4;
    localparam int DW = 4*COORD_BITS + 2*aatcr_pkg::SIZE_BITS + 5*WW;
    localparam int QW = DW + $bits(aatcr_pkg::t_ctrl);

    aatcr_pkg::t_ctrl w_f_ctrl;
    aatcr_pkg::t_ctrl w_b_ctrl;
    logic [DW-1:0]    w_f_data;
    logic [QW-1:0]    w_q_rd;
    logic             w_full;
    logic             w_empty;
    logic             w_take;

    aatcr_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_kind),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_size_w   (i_size_w),
        .i_size_h   (i_size_h),
        .i_speed_x  (i_speed_x),
        .i_speed_y  (i_speed_y),
        .i_tile_x   (i_tile_x),
        .i_tile_y   (i_tile_y),
        .i_solid    (i_solid),
        .o_ctrl     (w_f_ctrl),
        .o_data     (w_f_data)
    );

    aatcr_queue #(
        .WIDTH (QW),
        .DEPTH (aatcr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_valid),
        .i_wr_data ({w_f_ctrl, w_f_data}),
        .i_pop     (w_take),
        .o_rd_data (w_q_rd),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    assign o_stall  = w_full;
    assign w_b_ctrl = aatcr_pkg::t_ctrl'(w_q_rd[QW-1:DW]);

    aatcr_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (!w_empty),
        .i_ctrl        (w_b_ctrl),
        .i_data        (w_q_rd[DW-1:0]),
        .o_take        (w_take),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_new_x       (o_new_x),
        .o_new_y       (o_new_y),
        .o_new_vx      (o_new_vx),
        .o_new_vy      (o_new_vy),
        .o_hit         (o_hit),
        .o_pushed_on_y (o_pushed_on_y)
    );

endmodule

// ===== design/aatcr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the collision resolver, bound to the top level.
module aatcr_checker #(
    parameter int COORD_BITS = aatcr_pkg::COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [COORD_BITS-1:0] o_new_x,
    input logic signed [COORD_BITS-1:0] o_new_y,
    input logic signed [COORD_BITS-1:0] o_new_vx,
    input logic signed [COORD_BITS-1:0] o_new_vy,
    input logic                         o_hit,
    input logic                         o_pushed_on_y
);

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("queue or output not empty after reset");

    a_axis_needs_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> !o_pushed_on_y)
        else $error("push axis set without a hit");

    a_vy_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit && o_pushed_on_y |-> o_new_vy == '0)
        else $error("y velocity not cleared after y push");

    a_vx_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit && !o_pushed_on_y |-> o_new_vx == '0)
        else $error("x velocity not cleared after x push");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_x) && $stable(o_new_y))
        else $error("stalled result word changed");

endmodule

bind aabb_tile_collision_resolver_top aatcr_checker #(
    .COORD_BITS (COORD_BITS)
) u_aatcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_new_x       (o_new_x),
    .o_new_y       (o_new_y),
    .o_new_vx      (o_new_vx),
    .o_new_vy      (o_new_vy),
    .o_hit         (o_hit),
    .o_pushed_on_y (o_pushed_on_y)
);
